// ===== rtl/core/bgtu_pkg.sv =====
`default_nettype none
package bgtu_pkg;

    localparam int MAX_ROWS_DEF  = 8;
    localparam int MAX_COLS_DEF  = 8;
    localparam int MAX_DEPTH_DEF = 64;

    // request kinds
    localparam logic [1:0] KIND_LOAD_A  = 2'd0;
    localparam logic [1:0] KIND_LOAD_B  = 2'd1;
    localparam logic [1:0] KIND_LOAD_C  = 2'd2;
    localparam logic [1:0] KIND_COMPUTE = 2'd3;

    // configuration register indexes
    localparam logic [1:0] CFG_ROWS  = 2'd0;
    localparam logic [1:0] CFG_COLS  = 2'd1;
    localparam logic [1:0] CFG_DEPTH = 2'd2;
    localparam logic [1:0] CFG_ALPHA = 2'd3;

    localparam logic [31:0] FP32_QNAN = 32'h7FC0_0000;
    localparam logic [15:0] BF16_QNAN = 16'h7FC0;

    typedef enum logic {
        FP_MUL = 1'b0,
        FP_ADD = 1'b1
    } fp_op_t;

    typedef struct packed {
        logic   issue;
        fp_op_t op;
    } fp_ctrl_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ELEM,
        S_MUL,
        S_MUL_WAIT,
        S_ADD,
        S_ADD_WAIT,
        S_SCALE,
        S_SCALE_WAIT,
        S_TOTAL,
        S_TOTAL_WAIT,
        S_OUT
    } state_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [2:0]  row;
        logic [2:0]  col;
        logic [5:0]  depth_index;
        logic [15:0] value;
    } in_req_t;

    typedef struct packed {
        logic [2:0]  out_row;
        logic [2:0]  out_col;
        logic [15:0] out_value;
        logic        last;
    } out_req_t;

    function automatic logic [31:0] widen_bf16(input logic [15:0] v);
        return {v, 16'h0000};
    endfunction

    // fp32 -> bf16, round to nearest even, any NaN becomes the canonical one
    function automatic logic [15:0] narrow_bf16(input logic [31:0] w);
        logic [31:0] sum;
        sum = w + 32'h0000_7FFF + {31'b0, w[16]};
        if (w[30:23] == 8'hFF && w[22:0] != 23'b0)
            return BF16_QNAN;
        return sum[31:16];
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/bgtu_fp_unit.sv =====
`default_nettype none
// fp32 multiply or add, round to nearest even, subnormals kept.
// Two stages: exact wide result, then normalize and round.
module bgtu_fp_unit (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire bgtu_pkg::fp_ctrl_t ctrl,
    input  wire logic [31:0]       a,
    input  wire logic [31:0]       b,
    output logic                   done,
    output logic [31:0]            result
);

    // stage A registers
    logic               va_reg;
    logic               nan_reg, inf_reg, sign_reg;
    logic [50:0]        mant_reg;
    logic signed [11:0] x_reg;

    logic               nan_next, inf_next, sign_next;
    logic [50:0]        mant_next;
    logic signed [11:0] x_next;

    logic        done_reg;
    logic [31:0] result_reg, result_next;

    // operand decode
    logic        sa, sb, a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
    logic [23:0] ma, mb;
    logic [8:0]  xa, xb;
    logic        swap;
    logic        sbig;
    logic [23:0] mbig, msmall;
    logic [8:0]  xbig, xsmall, exp_gap;
    logic [5:0]  dc;
    logic [113:0] align_ext;
    logic [49:0] small_al;
    logic [47:0] prod;

    always_comb
    begin
        sa     = a[31];
        sb     = b[31];
        a_nan  = (a[30:23] == 8'hFF) && (a[22:0] != 23'b0);
        b_nan  = (b[30:23] == 8'hFF) && (b[22:0] != 23'b0);
        a_inf  = (a[30:23] == 8'hFF) && (a[22:0] == 23'b0);
        b_inf  = (b[30:23] == 8'hFF) && (b[22:0] == 23'b0);
        a_zero = (a[30:0] == 31'b0);
        b_zero = (b[30:0] == 31'b0);
        ma     = {a[30:23] != 8'h00, a[22:0]};
        mb     = {b[30:23] != 8'h00, b[22:0]};
        xa     = (a[30:23] == 8'h00) ? 9'd1 : {1'b0, a[30:23]};
        xb     = (b[30:23] == 8'h00) ? 9'd1 : {1'b0, b[30:23]};

        swap    = (b[30:0] > a[30:0]);
        sbig    = swap ? sb : sa;
        mbig    = swap ? mb : ma;
        msmall  = swap ? ma : mb;
        xbig    = swap ? xb : xa;
        xsmall  = swap ? xa : xb;
        exp_gap = xbig - xsmall;
        dc      = (exp_gap > 9'd63) ? 6'd63 : exp_gap[5:0];
        align_ext = {msmall, 26'b0, 64'b0} >> dc;
        small_al  = align_ext[113:64] | {49'b0, |align_ext[63:0]};
        prod      = ma * mb;

        if (ctrl.op == bgtu_pkg::FP_MUL)
        begin
            nan_next  = a_nan || b_nan || (a_inf && b_zero) || (a_zero && b_inf);
            inf_next  = a_inf || b_inf;
            sign_next = sa ^ sb;
            mant_next = {3'b0, prod};
            x_next    = $signed(12'({3'b0, xa}) + 12'({3'b0, xb}) - 12'd300);
        end
        else
        begin
            nan_next  = a_nan || b_nan || (a_inf && b_inf && (sa != sb));
            inf_next  = a_inf || b_inf;
            if (sa != sb)
                mant_next = {1'b0, mbig, 26'b0} - {1'b0, small_al};
            else
                mant_next = {1'b0, mbig, 26'b0} + {1'b0, small_al};
            // exact zero sum is +0 unless both operands are -0
            if (a_inf)
                sign_next = sa;
            else if (b_inf)
                sign_next = sb;
            else if (mant_next == 51'b0)
                sign_next = sa & sb;
            else
                sign_next = sbig;
            x_next = $signed(12'({3'b0, xbig}) - 12'd176);
        end
    end

    // stage B: normalize and round
    logic [5:0]         msb;
    logic signed [11:0] lsb_exp, shamt;
    logic [5:0]         rsh;
    logic [114:0]       round_ext;
    logic [24:0]        mfin;
    logic               rbit, sticky;
    logic [11:0]        base;
    logic [35:0]        field;

    always_comb
    begin
        msb = 6'd0;
        for (int i = 0; i < 51; i++)
        begin
            if (mant_reg[i])
                msb = 6'(i);
        end
        lsb_exp = x_reg + $signed({6'b0, msb}) - 12'sd23;
        if (lsb_exp < -12'sd149)
            lsb_exp = -12'sd149;
        shamt = lsb_exp - x_reg;
        rsh   = (shamt > 12'sd63) ? 6'd63 : shamt[5:0];
        round_ext = {mant_reg, 64'b0} >> rsh;
        rbit   = round_ext[63];
        sticky = |round_ext[62:0];
        if (shamt < 12'sd0)
            mfin = 25'(mant_reg << (-shamt));
        else
            mfin = round_ext[88:64] + {24'b0, rbit & (sticky | round_ext[64])};
        base  = 12'(lsb_exp + 12'sd149);
        field = {4'b0, base[8:0], 23'b0} + {11'b0, mfin};

        if (nan_reg)
            result_next = bgtu_pkg::FP32_QNAN;
        else if (inf_reg)
            result_next = {sign_reg, 8'hFF, 23'b0};
        else if (mant_reg == 51'b0)
            result_next = {sign_reg, 31'b0};
        else if (field >= 36'h0_7F80_0000)
            result_next = {sign_reg, 8'hFF, 23'b0};
        else
            result_next = {sign_reg, field[30:0]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            va_reg   <= ctrl.issue;
            done_reg <= va_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.issue)
        begin
            nan_reg  <= nan_next;
            inf_reg  <= inf_next;
            sign_reg <= sign_next;
            mant_reg <= mant_next;
            x_reg    <= x_next;
        end
        if (va_reg)
            result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule
`default_nettype wire

// ===== rtl/core/bf16_gemm_tile_update_unit.sv =====
`default_nettype none
// bf16 GEMM tile update, fp32 accumulate.
// Input channel (in_valid/in_stall/in_data): one request per item. Load A,
// load B and load C requests write one bf16 element into the A, B or C
// store by explicit index and give no result.
// A compute request walks the C tile column by column, rows ascending, and
// for each element forms an fp32 dot product over depth, scales it by
// alpha, adds the old C value and rounds to bf16. Each new value is written
// back to C and sent on the output channel (out_valid/out_stall/out_data);
// the final element carries last.
// All fp32 math runs through one shared two-stage multiply/add unit under
// a small sequencer: each depth step fetches the operands, issues the
// multiply and waits for it, then issues the add and waits for it; each
// element then closes with a fetch, the alpha scale, the C add and the
// output.
// in_stall is high for the whole compute. A stalled result holds the
// sequencer in place, with out_data stable, until it is taken.
// Reset clears the sequencer and sets rows=8, cols=8, depth=64, alpha=1.0;
// store contents are undefined until loaded. Configuration via cfg_write.
module bf16_gemm_tile_update_unit #(
    parameter int MAX_ROWS  = bgtu_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS  = bgtu_pkg::MAX_COLS_DEF,
    parameter int MAX_DEPTH = bgtu_pkg::MAX_DEPTH_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_write,
    input  wire logic [1:0]        cfg_index,
    input  wire logic [15:0]       cfg_data,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire bgtu_pkg::in_req_t in_data,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output bgtu_pkg::out_req_t     out_data
);

    localparam int A_DEPTH = MAX_ROWS * MAX_DEPTH;
    localparam int B_DEPTH = MAX_DEPTH * MAX_COLS;
    localparam int C_DEPTH = MAX_ROWS * MAX_COLS;
    localparam int AAW = (A_DEPTH > 1) ? $clog2(A_DEPTH) : 1;
    localparam int BAW = (B_DEPTH > 1) ? $clog2(B_DEPTH) : 1;
    localparam int CAW = (C_DEPTH > 1) ? $clog2(C_DEPTH) : 1;
    localparam int RW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CW  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int KW  = $clog2(MAX_DEPTH + 1);

    // configuration
    logic [3:0]  rows_reg, cols_reg;
    logic [6:0]  depth_reg;
    logic [15:0] alpha_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg  <= 4'd8;
            cols_reg  <= 4'd8;
            depth_reg <= 7'd64;
            alpha_reg <= 16'h3F80;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                bgtu_pkg::CFG_ROWS:  rows_reg  <= cfg_data[3:0];
                bgtu_pkg::CFG_COLS:  cols_reg  <= cfg_data[3:0];
                bgtu_pkg::CFG_DEPTH: depth_reg <= cfg_data[6:0];
                bgtu_pkg::CFG_ALPHA: alpha_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // saturated tile sizes
    logic [3:0]    nr, nc;
    logic [KW-1:0] nd;

    always_comb
    begin
        nr = (32'(rows_reg) > 32'(MAX_ROWS)) ? 4'(MAX_ROWS) : rows_reg;
        nc = (32'(cols_reg) > 32'(MAX_COLS)) ? 4'(MAX_COLS) : cols_reg;
        nd = (32'(depth_reg) > 32'(MAX_DEPTH)) ? KW'(MAX_DEPTH) : KW'(depth_reg);
    end

    // sequencer state
    bgtu_pkg::state_t   state_reg, state_next;
    logic [RW-1:0]      r_reg, r_next;
    logic [CW-1:0]      c_reg, c_next;
    logic [KW-1:0]      k_reg, k_next;
    logic [31:0]        sum_reg, sum_next;
    bgtu_pkg::out_req_t out_reg, out_next;

    // shared fp unit
    bgtu_pkg::fp_ctrl_t fp_ctrl;
    logic [31:0]        fp_a, fp_b, fp_res;
    logic               fp_done;

    bgtu_fp_unit u_fp (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (fp_ctrl),
        .a      (fp_a),
        .b      (fp_b),
        .done   (fp_done),
        .result (fp_res)
    );

    // stores
    logic [15:0] a_mem [A_DEPTH];
    logic [15:0] b_mem [B_DEPTH];
    logic [15:0] c_mem [C_DEPTH];
    logic [15:0] a_rd_reg, b_rd_reg, c_rd_reg;
    logic [AAW-1:0] a_raddr, a_waddr;
    logic [BAW-1:0] b_raddr, b_waddr;
    logic [CAW-1:0] c_raddr, c_waddr;
    logic        a_we, b_we, c_we;
    logic [15:0] c_wdata;

    logic in_take, out_take, is_compute, tile_last, load_a_ok, load_b_ok, load_c_ok;
    logic [15:0] new_value;

    always_comb
    begin
        in_take    = in_valid && (state_reg == bgtu_pkg::S_IDLE);
        out_take   = (state_reg == bgtu_pkg::S_OUT) && !out_stall;
        is_compute = in_data.kind == bgtu_pkg::KIND_COMPUTE;
        tile_last  = (32'(c_reg) + 32'd1 == 32'(nc)) && (32'(r_reg) + 32'd1 == 32'(nr));
        load_a_ok  = (32'(in_data.row) < 32'(MAX_ROWS))
                     && (32'(in_data.depth_index) < 32'(MAX_DEPTH));
        load_b_ok  = (32'(in_data.col) < 32'(MAX_COLS))
                     && (32'(in_data.depth_index) < 32'(MAX_DEPTH));
        load_c_ok  = (32'(in_data.row) < 32'(MAX_ROWS))
                     && (32'(in_data.col) < 32'(MAX_COLS));
        new_value  = bgtu_pkg::narrow_bf16(fp_res);

        a_raddr = AAW'(32'(r_reg) * MAX_DEPTH + 32'(k_reg));
        b_raddr = BAW'(32'(k_reg) * MAX_COLS + 32'(c_reg));
        c_raddr = CAW'(32'(r_reg) * MAX_COLS + 32'(c_reg));
        a_waddr = AAW'(32'(in_data.row) * MAX_DEPTH + 32'(in_data.depth_index));
        b_waddr = BAW'(32'(in_data.depth_index) * MAX_COLS + 32'(in_data.col));
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            bgtu_pkg::S_IDLE:
                if (in_take && is_compute && nr != 4'd0 && nc != 4'd0)
                    state_next = bgtu_pkg::S_ELEM;
            bgtu_pkg::S_ELEM:
                state_next = (k_reg == nd) ? bgtu_pkg::S_SCALE : bgtu_pkg::S_MUL;
            bgtu_pkg::S_MUL:
                state_next = bgtu_pkg::S_MUL_WAIT;
            bgtu_pkg::S_MUL_WAIT:
                if (fp_done)
                    state_next = bgtu_pkg::S_ADD;
            bgtu_pkg::S_ADD:
                state_next = bgtu_pkg::S_ADD_WAIT;
            bgtu_pkg::S_ADD_WAIT:
                if (fp_done)
                    state_next = bgtu_pkg::S_ELEM;
            bgtu_pkg::S_SCALE:
                state_next = bgtu_pkg::S_SCALE_WAIT;
            bgtu_pkg::S_SCALE_WAIT:
                if (fp_done)
                    state_next = bgtu_pkg::S_TOTAL;
            bgtu_pkg::S_TOTAL:
                state_next = bgtu_pkg::S_TOTAL_WAIT;
            bgtu_pkg::S_TOTAL_WAIT:
                if (fp_done)
                    state_next = bgtu_pkg::S_OUT;
            bgtu_pkg::S_OUT:
                if (!out_stall)
                    state_next = tile_last ? bgtu_pkg::S_IDLE : bgtu_pkg::S_ELEM;
            default:
                state_next = bgtu_pkg::S_IDLE;
        endcase
    end

    // outputs and datapath
    always_comb
    begin
        in_stall   = (state_reg != bgtu_pkg::S_IDLE);
        out_valid  = (state_reg == bgtu_pkg::S_OUT);
        fp_ctrl    = '{issue: 1'b0, op: bgtu_pkg::FP_MUL};
        fp_a       = sum_reg;
        fp_b       = fp_res;
        r_next     = r_reg;
        c_next     = c_reg;
        k_next     = k_reg;
        sum_next   = sum_reg;
        out_next   = out_reg;
        a_we       = 1'b0;
        b_we       = 1'b0;
        c_we       = 1'b0;
        c_waddr    = c_raddr;
        c_wdata    = new_value;

        case (state_reg)
            bgtu_pkg::S_IDLE:
            begin
                if (in_take)
                begin
                    case (in_data.kind)
                        bgtu_pkg::KIND_LOAD_A: a_we = load_a_ok;
                        bgtu_pkg::KIND_LOAD_B: b_we = load_b_ok;
                        bgtu_pkg::KIND_LOAD_C:
                        begin
                            c_we    = load_c_ok;
                            c_waddr = CAW'(32'(in_data.row) * MAX_COLS + 32'(in_data.col));
                            c_wdata = in_data.value;
                        end
                        default:
                        begin
                            r_next   = '0;
                            c_next   = '0;
                            k_next   = '0;
                            sum_next = 32'h0;
                        end
                    endcase
                end
            end
            bgtu_pkg::S_MUL:
            begin
                fp_ctrl = '{issue: 1'b1, op: bgtu_pkg::FP_MUL};
                fp_a    = bgtu_pkg::widen_bf16(a_rd_reg);
                fp_b    = bgtu_pkg::widen_bf16(b_rd_reg);
            end
            bgtu_pkg::S_ADD:
                fp_ctrl = '{issue: 1'b1, op: bgtu_pkg::FP_ADD};
            bgtu_pkg::S_ADD_WAIT:
            begin
                if (fp_done)
                begin
                    sum_next = fp_res;
                    k_next   = k_reg + 1'b1;
                end
            end
            bgtu_pkg::S_SCALE:
            begin
                fp_ctrl = '{issue: 1'b1, op: bgtu_pkg::FP_MUL};
                fp_b    = bgtu_pkg::widen_bf16(alpha_reg);
            end
            bgtu_pkg::S_TOTAL:
            begin
                fp_ctrl = '{issue: 1'b1, op: bgtu_pkg::FP_ADD};
                fp_a    = bgtu_pkg::widen_bf16(c_rd_reg);
            end
            bgtu_pkg::S_TOTAL_WAIT:
            begin
                if (fp_done)
                begin
                    c_we     = 1'b1;
                    out_next = '{out_row:   3'(r_reg),
                                 out_col:   3'(c_reg),
                                 out_value: new_value,
                                 last:      tile_last};
                end
            end
            bgtu_pkg::S_OUT:
            begin
                if (out_take)
                begin
                    k_next   = '0;
                    sum_next = 32'h0;
                    if (32'(r_reg) + 32'd1 == 32'(nr))
                    begin
                        r_next = '0;
                        c_next = c_reg + 1'b1;
                    end
                    else
                        r_next = r_reg + 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= bgtu_pkg::S_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        r_reg   <= r_next;
        c_reg   <= c_next;
        k_reg   <= k_next;
        sum_reg <= sum_next;
        out_reg <= out_next;
    end

    always_ff @(posedge clk)
    begin
        if (a_we)
            a_mem[a_waddr] <= in_data.value;
        a_rd_reg <= a_mem[a_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (b_we)
            b_mem[b_waddr] <= in_data.value;
        b_rd_reg <= b_mem[b_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (c_we)
            c_mem[c_waddr] <= c_wdata;
        c_rd_reg <= c_mem[c_raddr];
    end

    assign out_data = out_reg;

    // the fp unit only finishes while the sequencer waits on it
    assert property (@(posedge clk) disable iff (!rst_n)
        fp_done |-> (state_reg == bgtu_pkg::S_MUL_WAIT || state_reg == bgtu_pkg::S_ADD_WAIT
                     || state_reg == bgtu_pkg::S_SCALE_WAIT
                     || state_reg == bgtu_pkg::S_TOTAL_WAIT))
        else $error("fp result outside a wait state");

    // element position stays inside the tile while a result is shown
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (32'(out_data.out_row) < 32'(nr) && 32'(out_data.out_col) < 32'(nc)))
        else $error("result position outside tile");

    // a compute request on a non-empty tile starts the sequencer
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && in_data.kind == bgtu_pkg::KIND_COMPUTE
         && nr != 4'd0 && nc != 4'd0) |=> in_stall)
        else $error("compute request not started");

endmodule
`default_nettype wire
